// File: rtl/gcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants of the great-circle distance pipeline:
// Q2.30 formats, CORDIC arctangent table and unit conversion constants.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int unsigned CW = 34;
	localparam int unsigned STEPS = 30;
	localparam int unsigned SQ_STEPS = 31;
	localparam int unsigned RAD_LAT = 3;
	localparam int unsigned MUL_LAT = 3;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic [24:0] wdeg_t;
	typedef logic [30:0] q30u_t;
	typedef logic [27:0] dist_t;
	typedef logic [25:0] radius_t;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam q30u_t HALF_PI_Q30 = 31'd1686629713;
	localparam q30u_t ONE_Q30 = 31'd1073741824;
	localparam cval_t CORDIC_GAIN = 34'sd652032874;
	localparam logic [23:0] DEG90_Q16 = 24'd5898240;
	localparam logic [23:0] DEG180_Q16 = 24'd11796480;
	localparam logic [24:0] DEG360_Q16 = 25'd23592960;
	// pi in q30 split as 45 * PI_DIV45 + 26, 360 degrees in q16 is 45 * 2^19
	localparam logic [26:0] PI_DIV45 = 27'd74961320;
	localparam logic [4:0] PI_REM45 = 5'd26;
	localparam logic [30:0] RECIP45 = 31'd1527099484;
	localparam int unsigned RECIP45_SHIFT = 36;
	localparam radius_t RADIUS_RESET = 26'd6371000;

	localparam cval_t ATAN_Q30 [STEPS] = '{
		34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
		34'sd33543515, 34'sd16775850, 34'sd8388437, 34'sd4194282, 34'sd2097149,
		34'sd1048575, 34'sd524287, 34'sd262143, 34'sd131071, 34'sd65535,
		34'sd32767, 34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
		34'sd1023, 34'sd511, 34'sd255, 34'sd127, 34'sd63,
		34'sd31, 34'sd15, 34'sd8, 34'sd4, 34'sd2
	};

endpackage
`default_nettype wire

// File: rtl/great_circle_distance_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// great_circle_distance_unit
// Haversine great-circle distance between two points given in q16 degrees.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready take one request per cycle unless stalled: two
//    latitude/longitude pairs, signed degrees with 16 fraction bits
//  - output channel (out_valid/out_ready) returns one arc_distance per
//    request, in order, rounded to whole radius units
//  - cfg_ready is always high; cfg_valid writes sphere_radius, and the user
//    must do so only while no request is in flight: the block does not check
//  - an accepted request passes the unit conversion, the 30-step rotation
//    CORDIC, the multiplier stages, the 32-stage square root and the 30-step
//    vectoring CORDIC in series before out_valid
//  - throughput is one request per cycle while the receiver keeps up
//  - a two-entry output buffer sits after the pipeline; when it holds two
//    results the whole pipeline freezes and in_ready drops, nothing is lost
//  - reset empties the pipeline and the buffer and sets the radius to the
//    earth radius in metres
// ----------------------------------------------------------------------------
module great_circle_distance_unit import gcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] first_latitude,
	input  logic signed [24:0] first_longitude,
	input  logic signed [23:0] second_latitude,
	input  logic signed [24:0] second_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [27:0]        arc_distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [25:0]        sphere_radius
);

	localparam int unsigned NEG_LAT = RAD_LAT + STEPS;
	localparam logic signed [26:0] D360 = signed'(27'(DEG360_Q16));

	logic    en;
	radius_t radius_q;

	// difference and wrap stages
	logic               vld_s1, vld_s2;
	logic signed [24:0] dlat_s1;
	logic signed [25:0] dlon_s1;
	logic signed [23:0] lat1_s1, lat2_s1;
	wdeg_t              wdlat_s2, wdlon_s2, wlat1_s2, wlat2_s2;
	logic               neg_s2;
	logic signed [26:0] dlat_x, dlon_x, dlat_w, dlon_w;
	logic [23:0]        m1, m2, mf1, mf2;
	logic               n1, n2;

	// per-lane results
	logic  rad_vld;
	q30u_t r_dlat, r_dlon, r_lat1, r_lat2;
	logic  rot_vld;
	cval_t s_dlat, s_dlon, c_lat1, c_lat2, c1n;
	logic  neg_dly_q [NEG_LAT];
	logic  mul1_vld, mul2_vld;
	cval_t h_lat, h_lon, cc, prod_p;
	cval_t hlat_dly_q [MUL_LAT];

	logic               vld_a_s;
	q30u_t              a_s;
	logic signed [CW:0] asum;
	q30u_t              b_comb;
	logic               sq_vld;
	q30u_t              ra, rb;
	logic               vec_vld;
	cval_t              z_ang;
	logic               vld_c_s, vld_m_s;
	logic [31:0]        c_s;
	logic [57:0]        dprod_m_s;
	logic [58:0]        drnd;
	logic               push;

	assign cfg_ready = 1'b1;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= sphere_radius;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_a_s <= 1'b0;
			vld_c_s <= 1'b0;
			vld_m_s <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_a_s <= mul2_vld;
			vld_c_s <= vec_vld;
			vld_m_s <= vld_c_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= 25'(second_latitude) - 25'(first_latitude);
			dlon_s1 <= 26'(second_longitude) - 26'(first_longitude);
			lat1_s1 <= first_latitude;
			lat2_s1 <= second_latitude;
		end
	end

	// wrap differences into one turn, fold latitudes past the pole
	always_comb begin
		dlat_x = 27'(dlat_s1);
		dlon_x = 27'(dlon_s1);
		dlat_w = dlat_x[26] ? dlat_x + D360 : dlat_x;
		if (dlon_x < -D360) begin
			dlon_w = dlon_x + D360 + D360;
		end else if (dlon_x[26]) begin
			dlon_w = dlon_x + D360;
		end else if (dlon_x >= D360) begin
			dlon_w = dlon_x - D360;
		end else begin
			dlon_w = dlon_x;
		end
		m1  = lat1_s1[23] ? 24'(-lat1_s1) : 24'(lat1_s1);
		m2  = lat2_s1[23] ? 24'(-lat2_s1) : 24'(lat2_s1);
		n1  = (m1 > DEG90_Q16);
		n2  = (m2 > DEG90_Q16);
		mf1 = n1 ? DEG180_Q16 - m1 : m1;
		mf2 = n2 ? DEG180_Q16 - m2 : m2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wdlat_s2 <= dlat_w[24:0];
			wdlon_s2 <= dlon_w[24:0];
			wlat1_s2 <= {mf1, 1'b0};
			wlat2_s2 <= {mf2, 1'b0};
			neg_s2   <= n1 ^ n2;
		end
	end

	gcd_rad u_rad_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s2), .w(wdlat_s2),
		.vld_out(rad_vld), .r(r_dlat)
	);
	gcd_rad u_rad_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s2), .w(wdlon_s2),
		.vld_out(), .r(r_dlon)
	);
	gcd_rad u_rad_lat1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s2), .w(wlat1_s2),
		.vld_out(), .r(r_lat1)
	);
	gcd_rad u_rad_lat2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s2), .w(wlat2_s2),
		.vld_out(), .r(r_lat2)
	);

	gcd_cordic_rot u_rot_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rad_vld), .angle(r_dlat),
		.vld_out(rot_vld), .sin_out(s_dlat), .cos_out()
	);
	gcd_cordic_rot u_rot_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rad_vld), .angle(r_dlon),
		.vld_out(), .sin_out(s_dlon), .cos_out()
	);
	gcd_cordic_rot u_rot_lat1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rad_vld), .angle(r_lat1),
		.vld_out(), .sin_out(), .cos_out(c_lat1)
	);
	gcd_cordic_rot u_rot_lat2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rad_vld), .angle(r_lat2),
		.vld_out(), .sin_out(), .cos_out(c_lat2)
	);

	// sign of the cosine product follows the lanes alongside the cordics
	for (genvar i = 0; i < NEG_LAT; i++) begin : g_neg
		always_ff @(posedge clk) begin
			if (en) begin
				if (i == 0) begin
					neg_dly_q[i] <= neg_s2;
				end else begin
					neg_dly_q[i] <= neg_dly_q[i == 0 ? 0 : i-1];
				end
			end
		end
	end

	assign c1n = neg_dly_q[NEG_LAT-1] ? -c_lat1 : c_lat1;

	gcd_mul u_mul_hlat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rot_vld), .a(s_dlat), .b(s_dlat),
		.vld_out(mul1_vld), .p(h_lat)
	);
	gcd_mul u_mul_hlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rot_vld), .a(s_dlon), .b(s_dlon),
		.vld_out(), .p(h_lon)
	);
	gcd_mul u_mul_cc (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(rot_vld), .a(c1n), .b(c_lat2),
		.vld_out(), .p(cc)
	);
	gcd_mul u_mul_p (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(mul1_vld), .a(cc), .b(h_lon),
		.vld_out(mul2_vld), .p(prod_p)
	);

	for (genvar i = 0; i < MUL_LAT; i++) begin : g_hlat
		always_ff @(posedge clk) begin
			if (en) begin
				if (i == 0) begin
					hlat_dly_q[i] <= h_lat;
				end else begin
					hlat_dly_q[i] <= hlat_dly_q[i == 0 ? 0 : i-1];
				end
			end
		end
	end

	// haversine term, clamped to [0, 1]
	assign asum = (CW+1)'(hlat_dly_q[MUL_LAT-1]) + (CW+1)'(prod_p);

	always_ff @(posedge clk) begin
		if (en) begin
			if (asum[CW]) begin
				a_s <= '0;
			end else if (asum > (CW+1)'(ONE_Q30)) begin
				a_s <= ONE_Q30;
			end else begin
				a_s <= asum[30:0];
			end
		end
	end

	assign b_comb = ONE_Q30 - a_s;

	gcd_isqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_a_s), .v(a_s),
		.vld_out(sq_vld), .root(ra)
	);
	gcd_isqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_a_s), .v(b_comb),
		.vld_out(), .root(rb)
	);

	gcd_cordic_vec u_atan (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(sq_vld), .y_in(ra), .x_in(rb),
		.vld_out(vec_vld), .angle(z_ang)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_ang[CW-1]) begin
				c_s <= '0;
			end else if (z_ang > cval_t'(HALF_PI_Q30)) begin
				c_s <= {HALF_PI_Q30, 1'b0};
			end else begin
				c_s <= {z_ang[30:0], 1'b0};
			end
			dprod_m_s <= 58'(c_s) * 58'(radius_q);
		end
	end

	assign drnd = 59'(dprod_m_s) + (59'(1) << 29);
	assign push = vld_m_s && en;

	gcd_skid u_skid (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(drnd[57:30]),
		.take(out_ready), .vld(out_valid), .data(arc_distance), .room(en)
	);

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted request did not enter the pipeline");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (vld_s1 == $past(vld_s1)) && (vld_m_s == $past(vld_m_s)))
		else $error("pipeline moved while stalled");
	a_tail_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_m_s && en) |=> out_valid)
		else $error("finished result not presented");
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked with no result waiting");
`endif

endmodule
`default_nettype wire

// File: rtl/gcd_rad.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_rad
// Degrees (q16; latitudes arrive doubled) to q30 radians of half the angle,
// rounded, then folded into the first quadrant. Three stages.
// ----------------------------------------------------------------------------
module gcd_rad import gcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  wdeg_t w,
	output logic  vld_out,
	output q30u_t r
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [51:0] base_s1, base_s2;
	logic [29:0] x26_s1;
	logic [60:0] fprod_s2;
	q30u_t       r_s3;
	logic [52:0] sum;
	logic [31:0] rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// floor(x/45) by reciprocal, exact for x below 2^30
	always_ff @(posedge clk) begin
		if (en) begin
			base_s1  <= 52'(w) * 52'(PI_DIV45);
			x26_s1   <= 30'(w) * 30'(PI_REM45);
			base_s2  <= base_s1;
			fprod_s2 <= 61'(x26_s1) * 61'(RECIP45);
			r_s3     <= (rr > 32'(HALF_PI_Q30)) ? q30u_t'(PI_Q30 - rr) : q30u_t'(rr);
		end
	end

	always_comb begin
		sum = 53'(base_s2) + (53'(1) << 18) + 53'(fprod_s2[60:RECIP45_SHIFT]);
		rr  = sum[50:19];
	end

	assign vld_out = vld_s3;
	assign r       = r_s3;

endmodule
`default_nettype wire

// File: rtl/gcd_cordic_rot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_cordic_rot
// Unrolled rotation-mode CORDIC, one micro-rotation per stage, giving
// sin and cos of a first-quadrant angle.
// ----------------------------------------------------------------------------
module gcd_cordic_rot import gcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  q30u_t angle,
	output logic  vld_out,
	output cval_t sin_out,
	output cval_t cos_out
);

	cval_t x_s [STEPS];
	cval_t y_s [STEPS];
	cval_t z_s [STEPS];
	logic  vld_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		cval_t xp, yp, zp;
		logic  vp;
		if (i == 0) begin : g_first
			assign xp = CORDIC_GAIN;
			assign yp = '0;
			assign zp = cval_t'(angle);
			assign vp = vld_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = vld_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[CW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - ATAN_Q30[i];
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + ATAN_Q30[i];
				end
			end
		end
	end

	assign vld_out = vld_s[STEPS-1];
	assign sin_out = y_s[STEPS-1];
	assign cos_out = x_s[STEPS-1];

endmodule
`default_nettype wire

// File: rtl/gcd_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_mul
// Signed q30 product, rounded to nearest with halves away from zero.
// Three stages: magnitudes, product, round and sign.
// ----------------------------------------------------------------------------
module gcd_mul import gcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  cval_t a,
	input  cval_t b,
	output logic  vld_out,
	output cval_t p
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] ma_s1, mb_s1;
	logic        neg_s1, neg_s2;
	logic [63:0] prod_s2;
	cval_t       p_s3;
	cval_t       abs_a, abs_b;
	logic [63:0] rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		abs_a = a[CW-1] ? -a : a;
		abs_b = b[CW-1] ? -b : b;
		rnd   = prod_s2 + (64'(1) << 29);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= abs_a[31:0];
			mb_s1   <= abs_b[31:0];
			neg_s1  <= a[CW-1] ^ b[CW-1];
			prod_s2 <= 64'(ma_s1) * 64'(mb_s1);
			neg_s2  <= neg_s1;
			p_s3    <= neg_s2 ? -cval_t'(rnd[63:30]) : cval_t'(rnd[63:30]);
		end
	end

	assign vld_out = vld_s3;
	assign p       = p_s3;

endmodule
`default_nettype wire

// File: rtl/gcd_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_isqrt
// Rounded square root of a q30 value, one result bit per stage over the
// value shifted up by 30, then a rounding stage.
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  q30u_t v,
	output logic  vld_out,
	output q30u_t root
);

	logic [61:0] n_s   [SQ_STEPS];
	logic [61:0] res_s [SQ_STEPS];
	logic        vld_s [SQ_STEPS];
	logic        vld_r_s;
	q30u_t       root_r_s;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_bit
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * i);
		logic [61:0] np, rp, trial;
		logic        vp;
		if (i == 0) begin : g_first
			assign np = 62'(v) << 30;
			assign rp = '0;
			assign vp = vld_in;
		end else begin : g_next
			assign np = n_s[i-1];
			assign rp = res_s[i-1];
			assign vp = vld_s[i-1];
		end
		assign trial = rp + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (np >= trial) begin
					n_s[i]   <= np - trial;
					res_s[i] <= (rp >> 1) + BIT;
				end else begin
					n_s[i]   <= np;
					res_s[i] <= rp >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r_s <= 1'b0;
		end else if (en) begin
			vld_r_s <= vld_s[SQ_STEPS-1];
		end
	end

	// round up when the remainder exceeds the root
	always_ff @(posedge clk) begin
		if (en) begin
			if (n_s[SQ_STEPS-1] > res_s[SQ_STEPS-1]) begin
				root_r_s <= q30u_t'(res_s[SQ_STEPS-1] + 62'd1);
			end else begin
				root_r_s <= q30u_t'(res_s[SQ_STEPS-1]);
			end
		end
	end

	assign vld_out = vld_r_s;
	assign root    = root_r_s;

endmodule
`default_nettype wire

// File: rtl/gcd_cordic_vec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_cordic_vec
// Unrolled vectoring-mode CORDIC, one micro-rotation per stage, giving
// atan2(y, x) in q30 radians.
// ----------------------------------------------------------------------------
module gcd_cordic_vec import gcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  q30u_t y_in,
	input  q30u_t x_in,
	output logic  vld_out,
	output cval_t angle
);

	cval_t x_s [STEPS];
	cval_t y_s [STEPS];
	cval_t z_s [STEPS];
	logic  vld_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		cval_t xp, yp, zp;
		logic  vp;
		if (i == 0) begin : g_first
			assign xp = cval_t'(x_in);
			assign yp = cval_t'(y_in);
			assign zp = '0;
			assign vp = vld_in;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = vld_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (yp[CW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - ATAN_Q30[i];
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + ATAN_Q30[i];
				end
			end
		end
	end

	assign vld_out = vld_s[STEPS-1];
	assign angle   = z_s[STEPS-1];

endmodule
`default_nettype wire

// File: rtl/gcd_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_skid
// Two-entry output buffer. The room flag comes from a register, so the
// pipeline stall does not depend combinationally on the receiver.
// ----------------------------------------------------------------------------
module gcd_skid import gcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  dist_t push_data,
	input  logic  take,
	output logic  vld,
	output dist_t data,
	output logic  room
);

	dist_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign vld  = (cnt_q != 2'd0);
	assign pop  = vld && take;
	assign room = (cnt_q != 2'd2);
	assign data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/great_circle_distance_checker.sv
// ----------------------------------------------------------------------------
// great_circle_distance_checker
// Watches the request, result and radius channels of the distance unit,
// predicts each arc distance in fixed point and compares in order.
// ----------------------------------------------------------------------------
module great_circle_distance_checker import gcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [23:0] first_latitude,
	input  logic signed [24:0] first_longitude,
	input  logic signed [23:0] second_latitude,
	input  logic signed [24:0] second_longitude,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [27:0]        arc_distance,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [25:0]        sphere_radius,
	output int                 fail_count,
	output int                 pending
);

	localparam longint PI_L = 64'd3373259426;
	localparam longint HALF_PI_L = 64'd1686629713;
	localparam longint ONE_L = 64'd1073741824;
	localparam longint GAIN_L = 64'd652032874;
	localparam longint D90 = 64'd5898240;
	localparam longint D180 = 64'd11796480;
	localparam longint D360 = 64'd23592960;

	radius_t radius_copy;
	dist_t distances_due[$];

	function automatic longint qmul(longint a, longint b);
		longint unsigned ma, mb, r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		r = (ma * mb + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned root_q30(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		if (n > res)
			res++;
		return res;
	endfunction

	function automatic void rotate(longint z, output longint s, output longint c);
		longint x, y, dx, dy;
		x = GAIN_L;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
			end
		end
		s = y;
		c = x;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
			end
		end
		return z;
	endfunction

	// sin^2 of half a difference, difference wrapped into one turn first
	function automatic longint half_sin_sq(longint d);
		longint w, r, s, c;
		w = (d + 4 * D360) % D360;
		r = (w * PI_L + D360 / 2) / D360;
		if (r > HALF_PI_L)
			r = PI_L - r;
		rotate(r, s, c);
		return qmul(s, s);
	endfunction

	function automatic longint lat_cosine(longint lat);
		longint m, r, s, c;
		bit flip;
		m = (lat < 0) ? -lat : lat;
		flip = 0;
		if (m > D90) begin
			m = D180 - m;
			flip = 1;
		end
		r = (m * PI_L + D180 / 2) / D180;
		rotate(r, s, c);
		return flip ? -c : c;
	endfunction

	function automatic dist_t arc_for(longint lat1, longint lon1, longint lat2,
			longint lon2, radius_t rad);
		longint a, z;
		longint unsigned ra, rb, c;
		a = half_sin_sq(lat2 - lat1)
			+ qmul(qmul(lat_cosine(lat1), lat_cosine(lat2)), half_sin_sq(lon2 - lon1));
		if (a < 0)
			a = 0;
		if (a > ONE_L)
			a = ONE_L;
		ra = root_q30(longint'(a) << 30);
		rb = root_q30((ONE_L - a) << 30);
		z = vector_angle(ra, rb);
		if (z < 0)
			z = 0;
		if (z > HALF_PI_L)
			z = HALF_PI_L;
		c = 2 * z;
		return dist_t'((c * longint'(rad) + (64'd1 << 29)) >> 30);
	endfunction

	task automatic report(string what, dist_t got, dist_t want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_copy <= RADIUS_RESET;
			distances_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				radius_copy <= sphere_radius;
			if (in_valid && in_ready)
				distances_due.insert(distances_due.size(), arc_for(first_latitude,
					first_longitude, second_latitude, second_longitude, radius_copy));
			if (out_valid && out_ready) begin
				if (distances_due.size() == 0)
					report("unexpected arc_distance", arc_distance, 0);
				else if (arc_distance !== distances_due[0])
					report("arc_distance", arc_distance, distances_due.pop_front());
				else
					void'(distances_due.pop_front());
			end
		end
	end

	assign pending = distances_due.size();

endmodule

// File: tb/sv/great_circle_distance_unit_tb.sv
// ----------------------------------------------------------------------------
// great_circle_distance_unit_tb
// Drives directed and random point pairs through the distance unit under
// several radius settings, with random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module great_circle_distance_unit_tb;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [23:0] first_latitude = '0;
	logic signed [24:0] first_longitude = '0;
	logic signed [23:0] second_latitude = '0;
	logic signed [24:0] second_longitude = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [27:0] arc_distance;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [25:0] sphere_radius = '0;
	int fail_count;
	int pending;
	bit calm = 0;

	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;

	always #5 clk = ~clk;

	great_circle_distance_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_latitude(first_latitude), .first_longitude(first_longitude),
		.second_latitude(second_latitude), .second_longitude(second_longitude),
		.out_valid(out_valid), .out_ready(out_ready), .arc_distance(arc_distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sphere_radius(sphere_radius)
	);

	great_circle_distance_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_latitude(first_latitude), .first_longitude(first_longitude),
		.second_latitude(second_latitude), .second_longitude(second_longitude),
		.out_valid(out_valid), .out_ready(out_ready), .arc_distance(arc_distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .sphere_radius(sphere_radius),
		.fail_count(fail_count), .pending(pending)
	);

	task automatic send_pair(int lat1, int lon1, int lat2, int lon2);
		if (!calm && $urandom_range(99) < 15) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		first_latitude <= 24'(lat1);
		first_longitude <= 25'(lon1);
		second_latitude <= 24'(lat2);
		second_longitude <= 25'(lon2);
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic stop_requests();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_radius(logic [25:0] value);
		drain();
		cfg_valid <= 1;
		sphere_radius <= value;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic directed_pairs();
		send_pair(0, 0, 0, 0);
		send_pair(LAT_MAX, 0, -LAT_MAX, 0);
		send_pair(0, 0, 0, LON_MAX);
		send_pair(0, -LON_MAX, 0, LON_MAX);
		send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
		send_pair(-LAT_MAX, 0, -LAT_MAX, 12345);
		send_pair(1, 1, 0, 0);
		send_pair(0, 0, -1, -1);
		// latitudes past the pole
		send_pair(-8388608, 0, 8388607, 0);
		send_pair(8388607, -16777216, -8388608, 16777215);
		send_pair(6000000, 100, 7000000, -100);
		// longitudes wrapping past the date line
		send_pair(0, 16777215, 0, -16777216);
		send_pair(2000000, 11796000, 2000000, -11796000);
		send_pair(0, 0, 0, 23592960 / 2 + 1);
		// near antipodal points, where a rounds past one
		send_pair(3000000, 1000000, -3000000, 1000000 - LON_MAX);
		send_pair(LAT_MAX - 1, 5, -LAT_MAX + 1, 7);
		send_pair(0, 0, 1, LON_MAX - 1);
		send_pair(2949120, 0, 2949120, 3);
		send_pair(-1, -1, -1, -1);
		send_pair(8388607, 16777215, 8388607, 16777215);
	endtask

	task automatic random_pairs(int count);
		int lat1, lon1, lat2, lon2;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1: begin
					lat1 = {{8{1'b0}}, 24'($urandom)};
					lat1 = $signed(24'(lat1));
					lon1 = $signed(25'($urandom));
					lat2 = $signed(24'($urandom));
					lon2 = $signed(25'($urandom));
				end
				2: begin
					lat1 = $urandom_range(2 * LAT_MAX) - LAT_MAX;
					lon1 = $urandom_range(2 * LON_MAX) - LON_MAX;
					lat2 = -lat1 + $urandom_range(64) - 32;
					lon2 = lon1 + ((lon1 < 0) ? LON_MAX : -LON_MAX) + $urandom_range(64) - 32;
				end
				3: begin
					lat1 = $urandom_range(2 * LAT_MAX) - LAT_MAX;
					lon1 = $urandom_range(2 * LON_MAX) - LON_MAX;
					lat2 = lat1 + $urandom_range(2000) - 1000;
					lon2 = lon1 + $urandom_range(2000) - 1000;
				end
				default: begin
					lat1 = $urandom_range(2 * LAT_MAX) - LAT_MAX;
					lon1 = $urandom_range(2 * LON_MAX) - LON_MAX;
					lat2 = $urandom_range(2 * LAT_MAX) - LAT_MAX;
					lon2 = $urandom_range(2 * LON_MAX) - LON_MAX;
				end
			endcase
			send_pair(lat1, lon1, lat2, lon2);
		end
	endtask

	// result side: random idling, then one long hold-off to fill the pipeline
	initial begin
		int hold;
		repeat (11) @(posedge clk);
		repeat (150) begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
			@(posedge clk);
		end
		hold = 0;
		out_ready <= 0;
		while (hold < 300) begin
			@(posedge clk);
			hold++;
		end
		forever begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
			@(posedge clk);
		end
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_pairs();
		random_pairs(300);
		stop_requests();
		write_radius(26'd1);
		random_pairs(100);
		stop_requests();
		write_radius(26'h3FFFFFF);
		directed_pairs();
		calm = 1;
		random_pairs(200);
		calm = 0;
		stop_requests();
		write_radius(26'd0);
		random_pairs(40);
		stop_requests();
		write_radius(26'($urandom_range(67108863, 1)));
		random_pairs(270);
		stop_requests();
		drain();
		repeat (150) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
